@@ hdl/wba_pkg.sv @@
// shared widths, codes, state type and control structs for the weighted batch average
// no dependencies; compile first
package wba_pkg;

    localparam int VAL_W      = 16;   // q4.12 sample weight, element value and average
    localparam int PROD_W     = 32;   // q8.24 product
    localparam int ACC_W      = 48;   // q24.24 running total
    localparam int FRAC_BITS  = 12;
    localparam int DVD_W      = ACC_W - FRAC_BITS;   // dividend after dropping 12 frac bits
    localparam int IDX_W      = 8;
    localparam int VLEN_W     = 9;
    localparam int BATCH_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam int DEF_MAX_VECTOR_LENGTH = 256;
    localparam int DEF_MAX_BATCH         = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VECTOR_LENGTH = 1'b0,
        REG_BATCH_SIZE    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DLOAD,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic capture;      // take the request, read the entry, advance counters
        logic accumulate;   // form the total and write it back
        logic div_load;     // load magnitude and sign into the divider
        logic div_step;     // one quotient bit
        logic out_load;     // move the saturated quotient into the output register
    } cmd_t;

    typedef struct packed {
        logic last_sample;  // captured request belongs to the last sample of a batch
        logic div_last;     // divider on its final bit
        logic out_free;     // output register empty or being taken
    } status_t;

endpackage

@@ hdl/wba_if.sv @@
// valid/ready channel interfaces for requests, results and register writes
// depends on wba_pkg
interface wba_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [wba_pkg::VAL_W-1:0]  sample_weight;
    logic signed [wba_pkg::VAL_W-1:0]  element_value;

    modport source (output valid, output sample_weight, output element_value, input ready);
    modport sink   (input valid, input sample_weight, input element_value, output ready);
endinterface

interface wba_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wba_pkg::VAL_W-1:0]  average_value;
    logic        [wba_pkg::IDX_W-1:0]  element_index;
    logic                              last;

    modport source (output valid, output average_value, output element_index, output last,
                    input ready);
    modport sink   (input valid, input average_value, input element_index, input last,
                    output ready);
endinterface

interface wba_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [wba_pkg::CFG_IDX_W-1:0]        index;
    logic [wba_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/wba_ctrl.sv @@
// controller state machine for the weighted batch average
// depends on wba_pkg
module wba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wba_pkg::status_t   status,
    output wba_pkg::cmd_t      cmd
);

    wba_pkg::state_t state_reg;
    wba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            wba_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = wba_pkg::ST_ACC;
                end
            end
            wba_pkg::ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next = status.last_sample ? wba_pkg::ST_DLOAD : wba_pkg::ST_IDLE;
            end
            wba_pkg::ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = wba_pkg::ST_DIV;
            end
            wba_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = wba_pkg::ST_HOLD;
                end
            end
            wba_pkg::ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/wba_dpath.sv @@
// datapath: registers, counters, accumulator memory, bit-serial divider, output register
// depends on wba_pkg
module wba_dpath #(
    parameter int MAX_VECTOR_LENGTH = wba_pkg::DEF_MAX_VECTOR_LENGTH,
    parameter int MAX_BATCH         = wba_pkg::DEF_MAX_BATCH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wba_pkg::cmd_t                       cmd,
    output wba_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [wba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wba_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [wba_pkg::VAL_W-1:0]    sample_weight,
    input  logic signed [wba_pkg::VAL_W-1:0]    element_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wba_pkg::VAL_W-1:0]    average_value,
    output logic [wba_pkg::IDX_W-1:0]           element_index,
    output logic                                last
);

    localparam int EC_W = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
    localparam int SC_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int DVD_W = wba_pkg::DVD_W;
    localparam int REM_W = wba_pkg::BATCH_W + 1;
    localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(32767);
    localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(32768);

    // configuration
    logic [wba_pkg::VLEN_W-1:0]  vlen_reg;
    logic [wba_pkg::BATCH_W-1:0] batch_reg;
    logic [wba_pkg::VLEN_W-1:0]  len_eff;
    logic [wba_pkg::BATCH_W-1:0] nb_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg  <= wba_pkg::VLEN_W'(1);
            batch_reg <= wba_pkg::BATCH_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (wba_pkg::cfg_reg_t'(cfg_index))
                wba_pkg::REG_VECTOR_LENGTH: vlen_reg  <= cfg_data[wba_pkg::VLEN_W-1:0];
                wba_pkg::REG_BATCH_SIZE:    batch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (vlen_reg == '0)
            len_eff = wba_pkg::VLEN_W'(1);
        else if (32'(vlen_reg) > MAX_VECTOR_LENGTH)
            len_eff = wba_pkg::VLEN_W'(MAX_VECTOR_LENGTH);
        else
            len_eff = vlen_reg;
        if (batch_reg == '0)
            nb_eff = wba_pkg::BATCH_W'(1);
        else if (32'(batch_reg) > MAX_BATCH)
            nb_eff = wba_pkg::BATCH_W'(MAX_BATCH);
        else
            nb_eff = batch_reg;
    end

    // counters
    logic [EC_W-1:0] ec_reg;
    logic [SC_W-1:0] sc_reg;
    logic            last_elem;
    logic            last_samp;

    assign last_elem = (32'(ec_reg) + 32'd1) >= 32'(len_eff);
    assign last_samp = (32'(sc_reg) + 32'd1) >= 32'(nb_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg <= '0;
            sc_reg <= '0;
        end
        else if (cmd.capture)
        begin
            if (last_elem)
            begin
                ec_reg <= '0;
                sc_reg <= last_samp ? '0 : sc_reg + SC_W'(1);
            end
            else
            begin
                ec_reg <= ec_reg + EC_W'(1);
            end
        end
    end

    // captured request
    logic signed [wba_pkg::PROD_W-1:0] prod_reg;
    logic [EC_W-1:0]                   idx_reg;
    logic                              first_reg;
    logic                              last_samp_reg;
    logic                              last_elem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_reg      <= sample_weight * element_value;
            idx_reg       <= ec_reg;
            first_reg     <= (sc_reg == '0);
            last_samp_reg <= last_samp;
            last_elem_reg <= last_elem;
        end
    end

    // accumulator memory, registered read
    logic signed [wba_pkg::ACC_W-1:0] acc_mem [MAX_VECTOR_LENGTH];
    logic signed [wba_pkg::ACC_W-1:0] rd_data_reg;
    logic signed [wba_pkg::ACC_W-1:0] total;
    logic signed [wba_pkg::ACC_W-1:0] total_reg;

    assign total = first_reg ? wba_pkg::ACC_W'(prod_reg)
                             : rd_data_reg + wba_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= acc_mem[ec_reg];
        end
        if (cmd.accumulate)
        begin
            acc_mem[idx_reg] <= total;
            total_reg        <= total;
        end
    end

    // restoring divider on the magnitude, one quotient bit per cycle
    logic [wba_pkg::ACC_W-1:0]     mag;
    logic [DVD_W-1:0]              quo_reg;
    logic [REM_W-1:0]              rem_reg;
    logic                          neg_reg;
    logic [wba_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]              trial;
    logic                          ge;

    assign mag   = total_reg[wba_pkg::ACC_W-1] ? -total_reg : total_reg;
    assign trial = {rem_reg[REM_W-2:0], quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, nb_eff};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= mag[wba_pkg::ACC_W-1:wba_pkg::FRAC_BITS];
            rem_reg <= '0;
            neg_reg <= total_reg[wba_pkg::ACC_W-1];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? trial - {1'b0, nb_eff} : trial;
            cnt_reg <= cnt_reg + wba_pkg::DIV_CNT_W'(1);
        end
    end

    // saturation
    logic signed [wba_pkg::VAL_W-1:0] sat;

    always_comb
    begin
        if (neg_reg)
            sat = (quo_reg > NEG_LIM) ? wba_pkg::VAL_W'(16'sh8000)
                                      : -wba_pkg::VAL_W'(quo_reg[wba_pkg::VAL_W-1:0]);
        else
            sat = (quo_reg > POS_LIM) ? wba_pkg::VAL_W'(16'sh7FFF)
                                      : quo_reg[wba_pkg::VAL_W-1:0];
    end

    // output register
    logic                             out_valid_reg;
    logic signed [wba_pkg::VAL_W-1:0] avg_reg;
    logic [wba_pkg::IDX_W-1:0]        oidx_reg;
    logic                             olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_reg   <= sat;
            oidx_reg  <= wba_pkg::IDX_W'(idx_reg);
            olast_reg <= last_elem_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_value = avg_reg;
    assign element_index = oidx_reg;
    assign last          = olast_reg;

    assign status.last_sample = last_samp_reg;
    assign status.div_last    = (32'(cnt_reg) == DVD_W - 1);
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

@@ hdl/weighted_batch_average_core.sv @@
// top level of the weighted batch average: channels, register port, controller and datapath
// depends on wba_pkg, wba_if, wba_ctrl, wba_dpath
//
// usage
// - samples: one request per element, sample by sample, carrying the sample's weight
//   and one element value (both signed q4.12)
// - averages: one result per element of the last sample of each batch, with the
//   saturated weighted sum / batch size, its element index and a final-element mark
// - cfg: register writes (index 0 vector_length, index 1 batch_size), always ready;
//   write only while the block is idle
// - ready drops after each acceptance while the accumulator entry is written back
//   (memory read at acceptance, then write-back)
// - a request of the last sample presents its result after the write-back, the
//   divider load, the bit-serial divide over 36 quotient bits and the move into the
//   output register; meanwhile no further request is taken
// - the output register holds a result while the receiver stalls; the next request
//   is taken as soon as the result is in that register, but the following result
//   waits until the register is free
// - reset clears counters, registers to 1 and the output valid; accumulators hold
//   nothing defined until the first sample of a batch writes them
module weighted_batch_average_core #(
    parameter int MAX_VECTOR_LENGTH = wba_pkg::DEF_MAX_VECTOR_LENGTH,
    parameter int MAX_BATCH         = wba_pkg::DEF_MAX_BATCH
) (
    input  logic      clk,
    input  logic      rst_n,
    wba_in_if.sink    samples,
    wba_out_if.source averages,
    wba_cfg_if.sink   cfg
);

    wba_pkg::cmd_t    cmd;
    wba_pkg::status_t status;

    // register writes never stall
    assign cfg.ready = 1'b1;

    // sequencing of capture, write-back, divide and output
    wba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    wba_dpath #(
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .MAX_BATCH         (MAX_BATCH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .sample_weight (samples.sample_weight),
        .element_value (samples.element_value),
        .out_valid     (averages.valid),
        .out_ready     (averages.ready),
        .average_value (averages.average_value),
        .element_index (averages.element_index),
        .last          (averages.last)
    );

endmodule

@@ hdl/wba_checker.sv @@
// port-level checks for the weighted batch average, bound to the top level
// depends on wba_pkg, weighted_batch_average_core
module wba_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [wba_pkg::VAL_W-1:0] average_value,
    input logic                             cfg_ready
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_value))
        else $error("result dropped or changed while stalled");

    // one request at a time
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken in consecutive cycles");

    // a new result only appears after the divide, when no request was being taken
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a busy period");

    // register port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register port not ready");

endmodule

bind weighted_batch_average_core wba_checker u_wba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (averages.valid),
    .out_ready     (averages.ready),
    .average_value (averages.average_value),
    .cfg_ready     (cfg.ready)
);
